[rtl/wst_pkg.sv]
package wst_pkg;

  // Sizes
  localparam int MAX_WINDOW_DEF = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int WIDTH_W        = 5;
  localparam int THR_W          = 31;
  localparam int STEP_W         = 32;
  localparam int SLOPE_W        = 32;
  localparam int Q_W            = SLOPE_W + 1;
  localparam int DIV_STEPS      = 32;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 2'd2;

  // Reset values
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 5'd5;
  localparam logic [THR_W-1:0]   THR_RST   = 31'd6554;
  localparam logic [STEP_W-1:0]  STEP_RST  = 32'd65536;
  localparam logic [SLOPE_W-1:0] SLOPE_RST = 32'd1;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    DIR_FLAT = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DEN,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic walk;
    logic den;
    logic prep;
    logic div;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic walk_done;
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/wst_in_if.sv]
interface wst_in_if;
  import wst_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[rtl/wst_out_if.sv]
interface wst_out_if;
  import wst_pkg::*;

  logic               valid;
  logic               ready;
  logic               slope_new;
  logic [SLOPE_W-1:0] slope;
  logic [1:0]         direction;

  modport source (output valid, output slope_new, output slope, output direction, input ready);
  modport sink (input valid, input slope_new, input slope, input direction, output ready);
endinterface

[rtl/wst_ram.sv]
module wst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/wst_ctrl.sv]
module wst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wst_pkg::sts_t sts,
  output wst_pkg::cmd_t cmd
);
  import wst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.complete ? ST_SETUP : ST_EMIT;
        end
      end
      ST_SETUP: state_nxt = ST_WALK;
      ST_WALK: begin
        if (sts.walk_done) begin
          state_nxt = ST_DEN;
        end
      end
      ST_DEN:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = sts.need_div ? ST_DIV : ST_FIN;
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_WALK:  cmd.walk  = 1'b1;
      ST_DEN:   cmd.den   = 1'b1;
      ST_PREP:  cmd.prep  = 1'b1;
      ST_DIV:   cmd.div   = 1'b1;
      ST_FIN:   cmd.fin   = 1'b1;
      ST_EMIT:  cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_branch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_SETUP || state_r == ST_EMIT))
    else $error("accepted item did not start a fit or a result");
`endif
endmodule

[rtl/wst_datapath.sv]
module wst_datapath #(
  parameter int MAX_WINDOW = wst_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [wst_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wst_pkg::cmd_t                   cmd,
  output wst_pkg::sts_t                   sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_slope_new,
  output logic [wst_pkg::SLOPE_W-1:0]     out_slope,
  output logic [1:0]                      out_direction
);
  import wst_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CF_W   = 2 * CNT_W + 1;
  localparam int PY_W   = CF_W + SAMPLE_BITS + 1;
  localparam int PD_W   = CF_W + CNT_W + 1;
  localparam int ACC_W  = PY_W + CNT_W;
  localparam int DACC_W = PD_W + CNT_W;
  localparam int D_W    = DACC_W - 1;
  localparam int DEN_W  = STEP_W + D_W;
  localparam int CMP_W  = ((ACC_W > DEN_W) ? ACC_W : DEN_W) + 1;

  // Configuration
  logic [WIDTH_W-1:0] width_r;
  logic [THR_W-1:0]   thr_r;
  logic [STEP_W-1:0]  step_r;

  logic [CNT_W-1:0]   w_eff;
  logic [IDX_W-1:0]   wptr_r;
  logic [CNT_W-1:0]   fill_r;
  logic               fresh_r;

  // Window walk
  logic [IDX_W-1:0]       addr_r;
  logic [IDX_W-1:0]       start_addr;
  logic [CNT_W:0]         start_sum;
  logic [CNT_W-1:0]       issue_r;
  logic                   mac_vld_r;
  logic signed [CF_W-1:0] coeff_r;
  logic signed [CF_W-1:0] coeff_d_r;
  logic [CNT_W-1:0]       idx_d_r;
  logic [2*CNT_W-1:0]     w_prod;
  logic [SAMPLE_BITS-1:0] rdata;
  logic signed [PY_W-1:0] py;
  logic signed [PD_W-1:0] pd;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DACC_W-1:0] dacc_r;

  // Division
  logic [DEN_W-1:0] den_prod;
  logic [DEN_W-1:0] den_r;
  logic [ACC_W-1:0] mag_r;
  logic             neg_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   rem_sh;
  logic             rem_ge;
  logic [Q_W-1:0]   q_r;
  logic [DIV_CNT_W-1:0] bit_r;
  logic             q_sat;

  logic signed [SLOPE_W-1:0] slope_r;
  logic [SLOPE_W-1:0]        slope_fin;
  logic [SLOPE_W:0]          s_mag;
  dir_t                      dir;

  logic               out_valid_r;
  logic               out_new_r;
  logic [SLOPE_W-1:0] out_slope_r;
  dir_t               out_dir_r;

  // Clamp the programmed width to the supported range
  always_comb begin
    if (width_r < WIDTH_W'(2)) begin
      w_eff = CNT_W'(2);
    end else if (32'(width_r) > 32'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(width_r);
    end
  end

  // Oldest sample of the window sits w_eff slots behind the write pointer
  always_comb begin
    if ((CNT_W+1)'(wptr_r) >= (CNT_W+1)'(w_eff)) begin
      start_sum = (CNT_W+1)'(wptr_r) - (CNT_W+1)'(w_eff);
    end else begin
      start_sum = (CNT_W+1)'(wptr_r) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(w_eff);
    end
    start_addr = IDX_W'(start_sum);
  end

  assign w_prod = w_eff * (w_eff - 1'b1);
  assign py     = coeff_d_r * $signed({1'b0, rdata});
  assign pd     = coeff_d_r * $signed({1'b0, idx_d_r});

  assign den_prod = step_r * dacc_r[D_W-1:0];

  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_r};
  assign q_sat  = q_r[Q_W-1:SLOPE_W-1] != '0;

  always_comb begin
    if (neg_r) begin
      slope_fin = q_sat ? SLOPE_MIN : SLOPE_W'(0) - q_r[SLOPE_W-1:0];
    end else begin
      slope_fin = q_sat ? SLOPE_MAX : q_r[SLOPE_W-1:0];
    end
  end

  always_comb begin
    s_mag = slope_r[SLOPE_W-1] ? (SLOPE_W+1)'(0) - {slope_r[SLOPE_W-1], slope_r}
                               : {1'b0, slope_r};
    if (s_mag < (SLOPE_W+1)'(thr_r)) begin
      dir = DIR_FLAT;
    end else if (!slope_r[SLOPE_W-1] && slope_r != '0) begin
      dir = DIR_POS;
    end else begin
      dir = DIR_NEG;
    end
  end

  assign sts.complete  = ((CNT_W+1)'(fill_r) + 1'b1) >= (CNT_W+1)'(w_eff);
  assign sts.walk_done = (issue_r == w_eff) && !mac_vld_r;
  assign sts.need_div  = (mag_r != '0) && (den_r != '0) && (CMP_W'(mag_r) < CMP_W'(den_r));
  assign sts.div_last  = bit_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts.out_free  = !out_valid_r || out_ready;

  wst_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_window (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(wptr_r),
    .wdata(in_sample),
    .raddr(addr_r),
    .rdata(rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      thr_r       <= THR_RST;
      step_r      <= STEP_RST;
      wptr_r      <= '0;
      fill_r      <= '0;
      slope_r     <= SLOPE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_WIDTH:   width_r <= cfg_wdata[WIDTH_W-1:0];
          REG_FLAT_THRESHOLD: thr_r   <= cfg_wdata[THR_W-1:0];
          REG_TIME_STEP:      step_r  <= cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        wptr_r <= (wptr_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : wptr_r + 1'b1;
        fill_r <= sts.complete ? CNT_W'(1) : fill_r + 1'b1;
      end
      if (cmd.fin) begin
        slope_r <= slope_fin;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk, accumulate, divide
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fresh_r <= sts.complete;
    end
    if (cmd.setup) begin
      addr_r    <= start_addr;
      issue_r   <= '0;
      mac_vld_r <= 1'b0;
      coeff_r   <= CF_W'(0) - CF_W'({2'b00, w_prod[2*CNT_W-1:1]});
      acc_r     <= '0;
      dacc_r    <= '0;
    end
    if (cmd.walk) begin
      if (issue_r != w_eff) begin
        addr_r    <= (addr_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : addr_r + 1'b1;
        issue_r   <= issue_r + 1'b1;
        coeff_r   <= coeff_r + $signed(CF_W'(w_eff));
        coeff_d_r <= coeff_r;
        idx_d_r   <= issue_r;
        mac_vld_r <= 1'b1;
      end else begin
        mac_vld_r <= 1'b0;
      end
      if (mac_vld_r) begin
        acc_r  <= acc_r + ACC_W'(py);
        dacc_r <= dacc_r + DACC_W'(pd);
      end
    end
    if (cmd.den) begin
      den_r <= den_prod;
      neg_r <= acc_r[ACC_W-1];
      mag_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    end
    if (cmd.prep) begin
      bit_r <= '0;
      rem_r <= DEN_W'(mag_r);
      if (mag_r == '0 || sts.need_div) begin
        q_r <= '0;
      end else begin
        q_r <= {1'b1, {SLOPE_W{1'b0}}};
      end
    end
    if (cmd.div) begin
      rem_r <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      q_r   <= {q_r[Q_W-2:0], rem_ge};
      bit_r <= bit_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_new_r   <= fresh_r;
      out_slope_r <= slope_r;
      out_dir_r   <= dir;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slope_new = out_new_r;
  assign out_slope     = out_slope_r;
  assign out_direction = out_dir_r;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CNT_W'(MAX_WINDOW))
    else $error("fill count beyond window depth");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.den |-> (!dacc_r[DACC_W-1] && dacc_r != '0))
    else $error("fit denominator not positive");
`endif
endmodule

[rtl/windowed_slope_tracker.sv]
// Results: an item that does not close a window is passed on without a fit; one that closes
//   a window of W samples runs the fit, and the divider is skipped when the numerator is
//   zero or not below the divisor.
// Throughput: one item at a time; the window walk (one RAM read per sample) and the
//   32-step restoring divider set the fit time. An item may be taken while a result waits.
// Reset: synchronous, active low; clears the fill count, sets the slope to the smallest
//   positive step and loads the register defaults. The sample RAM is not cleared.
module windowed_slope_tracker #(
  parameter int MAX_WINDOW = wst_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0] cfg_wdata,
  wst_in_if.sink                         in_ch,
  wst_out_if.source                      out_ch
);
  import wst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: IDLE takes a transfer. A sample that closes a window runs
  // SETUP (oldest address, first coefficient), WALK (read each sample from
  // the RAM and accumulate the numerator and denominator sums), DEN (form
  // time_step * D and the numerator magnitude), PREP (zero and saturation
  // cases), DIV (if needed; one quotient bit per cycle) and FIN (saturate to Q16.16).
  // Every item ends in EMIT, which loads the output register once it is free.
  wst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Datapath: configuration registers, circular sample buffer, MAC,
  // divider, latest slope and the output register.
  wst_datapath #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_sample    (in_ch.sample),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_slope_new(out_ch.slope_new),
    .out_slope    (out_ch.slope),
    .out_direction(out_ch.direction)
  );
endmodule

[dv/slope_checker.sv]
module slope_checker
  import wst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_slope_new,
  input  logic [SLOPE_W-1:0]     out_slope,
  input  logic [1:0]             out_direction,
  output int                     mismatches,
  output int                     open_count
);

  typedef struct packed {
    logic               fresh;
    logic [SLOPE_W-1:0] slope;
    dir_t               direction;
  } slope_result_t;

  // Shadow of the block: sample history (newest at 0), fill count, slope, registers
  logic [SAMPLE_BITS-1:0] window_q [MAX_WINDOW_DEF];
  int unsigned            fill_count;
  logic [SLOPE_W-1:0]     latest_slope;
  logic [WIDTH_W-1:0]     window_width;
  logic [THR_W-1:0]       flat_threshold;
  logic [STEP_W-1:0]      time_step;

  slope_result_t expected_slopes [$];
  slope_result_t want;
  int unsigned   span;

  function automatic int unsigned active_width();
    if (window_width < 2) return 2;
    if (window_width > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return window_width;
  endfunction

  // Least-squares slope of the newest w samples, Q16.16, truncated and saturated
  function automatic logic [SLOPE_W-1:0] fit_window_slope(input int unsigned w);
    longint            half;
    longint            num;
    longint unsigned   sum_i;
    longint unsigned   sum_i2;
    longint unsigned   d;
    longint unsigned   den;
    longint unsigned   mag;
    logic [95:0]       quotient;
    logic [SLOPE_W:0]  q;
    bit                neg;
    half   = longint'(w * (w - 1) / 2);
    num    = 0;
    sum_i  = 0;
    sum_i2 = 0;
    for (int unsigned i = 0; i < w; i++) begin
      num    = num + (longint'(w) * longint'(i) - half) * longint'(window_q[w - 1 - i]);
      sum_i  = sum_i + i;
      sum_i2 = sum_i2 + i * i;
    end
    d   = w * sum_i2 - sum_i * sum_i;
    den = 64'(time_step) * d;
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag == 0) return '0;
    if (den == 0 || mag >= den) begin
      q = 33'h1_0000_0000;
    end else begin
      quotient = {mag, 32'd0} / {32'd0, den};
      q = quotient[SLOPE_W:0];
    end
    if (neg) begin
      if (q >= 33'h0_8000_0000) return SLOPE_MIN;
      return 32'd0 - q[SLOPE_W-1:0];
    end
    if (q > 33'h0_7FFF_FFFF) return SLOPE_MAX;
    return q[SLOPE_W-1:0];
  endfunction

  function automatic dir_t heading_of(input logic [SLOPE_W-1:0] s);
    logic [SLOPE_W:0] m;
    m = s[SLOPE_W-1] ? ({1'b0, ~s} + 1'b1) : {1'b0, s};
    if (m < {2'b00, flat_threshold}) return DIR_FLAT;
    if (!s[SLOPE_W-1] && s != '0) return DIR_POS;
    return DIR_NEG;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (window_q[i]) window_q[i] = '0;
      fill_count     = 0;
      latest_slope   = SLOPE_RST;
      window_width   = WIDTH_RST;
      flat_threshold = THR_RST;
      time_step      = STEP_RST;
      mismatches     = 0;
      expected_slopes.delete();
    end else begin
      // Retire the oldest expectation against each result transfer
      if (out_valid && out_ready) begin
        if (expected_slopes.size() == 0) begin
          $display("%0t: unexpected result: got new=%0b slope=%h dir=%0d",
                   $time, out_slope_new, out_slope, out_direction);
          mismatches = mismatches + 1;
        end else begin
          want = expected_slopes.pop_front();
          if (out_slope_new !== want.fresh || out_slope !== want.slope ||
              out_direction !== want.direction) begin
            $display("%0t: result mismatch: expected new=%0b slope=%h dir=%0d, got new=%0b slope=%h dir=%0d",
                     $time, want.fresh, want.slope, want.direction,
                     out_slope_new, out_slope, out_direction);
            mismatches = mismatches + 1;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_WIDTH:   window_width   = cfg_wdata[WIDTH_W-1:0];
          REG_FLAT_THRESHOLD: flat_threshold = cfg_wdata[THR_W-1:0];
          REG_TIME_STEP:      time_step      = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        span = active_width();
        for (int i = MAX_WINDOW_DEF - 1; i > 0; i--) window_q[i] = window_q[i - 1];
        window_q[0] = in_sample;
        fill_count  = fill_count + 1;
        want.fresh  = 1'b0;
        if (fill_count >= span) begin
          latest_slope = fit_window_slope(span);
          fill_count   = 1;
          want.fresh   = 1'b1;
        end
        want.slope     = latest_slope;
        want.direction = heading_of(latest_slope);
        expected_slopes.push_back(want);
      end
    end
    open_count <= expected_slopes.size();
  end

endmodule

[dv/testbench.sv]
module testbench;
  import wst_pkg::*;

  // Leave a wide margin above the worst case per item.
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned MAX_IDLE    = 13;
  // Let the block settle past the longest fit, that of a 16-sample window.
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef enum {PAT_NOISE, PAT_FLAT, PAT_RAMP} sample_pattern_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int          mismatches;
  int          open_count;
  int unsigned cycle_count = 0;

  // Shared with the result drain: calm turns off all idling, hold_off_cycles
  // requests one long stall of the receiver.
  bit          calm;
  int unsigned hold_off_cycles;

  wst_in_if  in_ch ();
  wst_out_if out_ch ();

  windowed_slope_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  slope_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_sample     (in_ch.sample),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_slope_new (out_ch.slope_new),
    .out_slope     (out_ch.slope),
    .out_direction (out_ch.direction),
    .mismatches    (mismatches),
    .open_count    (open_count)
  );

  always #10 clk = ~clk;

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one sample: idle for a random gap, then hold valid until the transfer.
  // Valid stays high on return so back-to-back items need no extra NBA.
  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] value);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= value;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Write all three registers on consecutive edges; the block must be idle.
  task automatic program_registers(input logic [31:0] width_word,
                                   input logic [31:0] thr_word,
                                   input logic [31:0] step_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_WIDTH;
    cfg_wdata <= width_word;
    @(posedge clk);
    cfg_index <= REG_FLAT_THRESHOLD;
    cfg_wdata <= thr_word;
    @(posedge clk);
    cfg_index <= REG_TIME_STEP;
    cfg_wdata <= step_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid, wait until every expected result has come back, then let the
  // block sit for a tail of cycles.
  task automatic drain_and_settle(input int unsigned tail);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Result drain: stall for a random count, then accept one result.
  initial begin : result_drain
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : stimulus
    int unsigned     items_sent;
    int unsigned     phase_items;
    int unsigned     phase_index;
    sample_pattern_t pattern;
    int              level;
    int              stride;
    logic [15:0]     value;
    logic [31:0]     width_word;
    logic [31:0]     thr_word;
    logic [31:0]     step_word;

    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_WINDOW_WIDTH;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    calm            = 1'b0;
    hold_off_cycles = 0;
    items_sent      = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults (width 5): a step up to full scale, a step down, a small
    // ramp and a plateau. Sixteen samples also fill the whole history so later
    // wide windows never reach unwritten entries.
    offer_sample(16'd0);
    repeat (4) offer_sample(16'hFFFF);
    repeat (4) offer_sample(16'd0);
    for (int k = 1; k <= 4; k++) offer_sample(16'(k * 100));
    repeat (3) offer_sample(16'd400);
    items_sent = 16;
    drain_and_settle(SETTLE_CYCLES);

    // Width below range (acts as 2, upper bits set), zero threshold, zero time
    // step: slopes saturate toward the sign, and a level pair gives exactly zero.
    program_registers(32'hFFFF_FFE1, 32'd0, 32'd0);
    offer_sample(16'hFFFF);
    offer_sample(16'd0);
    offer_sample(16'd0);
    items_sent = items_sent + 3;
    drain_and_settle(SETTLE_CYCLES);

    // Width above range (acts as 16), threshold with its unused top bit set,
    // largest time step; then lower the width while a window is partly full.
    program_registers(32'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_sample(16'hFFFF);
    offer_sample(16'd0);
    offer_sample(16'd12345);
    offer_sample(16'd54321);
    drain_and_settle(SETTLE_CYCLES);
    program_registers(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_sample(16'd1);
    items_sent = items_sent + 5;
    drain_and_settle(SETTLE_CYCLES);

    // Random phases: fresh settings, then a run of samples of one pattern.
    phase_index = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       width_word = $urandom_range(0, 31);
        1:       width_word = 32'd16;
        2:       width_word = 32'd2;
        default: width_word = $urandom_range(2, 16);
      endcase
      if ($urandom_range(0, 3) == 0) width_word[31:WIDTH_W] = (32 - WIDTH_W)'($urandom);

      case ($urandom_range(0, 5))
        0:       thr_word = 32'd0;
        1:       thr_word = 32'h7FFF_FFFF;
        2:       thr_word = $urandom_range(0, 1 << 16);
        3:       thr_word = $urandom_range(0, 1 << 24);
        4:       thr_word = $urandom;
        default: thr_word = $urandom_range(0, 1 << 20);
      endcase
      thr_word[31] = 1'($urandom_range(0, 1));

      case ($urandom_range(0, 7))
        0:       step_word = 32'd0;
        1:       step_word = 32'd1;
        2:       step_word = 32'hFFFF_FFFF;
        3:       step_word = $urandom;
        4:       step_word = 32'd65536;
        default: step_word = $urandom_range(1 << 12, 1 << 20);
      endcase

      program_registers(width_word, thr_word, step_word);

      calm = ($urandom_range(0, 4) == 0);
      // Once: starve the output while the sender streams, so the block backs up.
      if (phase_index == 1) begin
        calm            = 1'b1;
        hold_off_cycles = 400;
      end

      pattern = sample_pattern_t'($urandom_range(0, 2));
      level   = $urandom_range(0, 65528);
      stride  = $urandom_range(0, 600);
      stride  = stride - 300;
      phase_items = $urandom_range(20, 90);

      for (int unsigned k = 0; k < phase_items; k++) begin
        case (pattern)
          PAT_NOISE: value = 16'($urandom);
          PAT_FLAT:  value = 16'(level + int'($urandom_range(0, 7)));
          default: begin
            // Ramp with a little noise; bounce off the rails.
            level = level + stride + int'($urandom_range(0, 8)) - 4;
            if (level < 0) begin
              level  = 0;
              stride = -stride;
            end else if (level > 65535) begin
              level  = 65535;
              stride = -stride;
            end
            value = 16'(level);
          end
        endcase
        offer_sample(value);
        items_sent = items_sent + 1;
      end

      drain_and_settle(SETTLE_CYCLES);
      phase_index = phase_index + 1;
    end

    if (mismatches == 0 && open_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
